// ===== design/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation core.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

	// width of the operand and result ports
	localparam int unsigned FIELD_W = 32;

	// exponent sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_LAUNCH,
		ST_MUL,
		ST_FINISH
	} mexp_state_t;

endpackage : mexp_pkg

`default_nettype wire

// ===== design/mexp_modred.sv =====
// ----------------------------------------------------------------------------
// mexp_modred
// Bit-serial restoring reduction: rem = value mod m, one dividend bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_modred #(
	parameter int unsigned WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [WIDTH-1:0] value,
	input  wire logic [WIDTH-1:0] m,
	output logic                  fin,
	output logic [WIDTH-1:0]      rem
);

	localparam int unsigned CW = $clog2(WIDTH);

	logic             active_q;
	logic             fin_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] r_q;
	logic [WIDTH-1:0] v_q;
	logic [WIDTH-1:0] m_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic [WIDTH-1:0] r_next;

	// shift in the next dividend bit, subtract the modulus when it fits
	always_comb begin
		trial  = {r_q, v_q[WIDTH-1]};
		diff   = trial - {1'b0, m_q};
		r_next = diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			fin_q    <= 1'b0;
			cnt_q    <= '0;
		end else begin
			fin_q <= 1'b0;
			if (go) begin
				active_q <= 1'b1;
				cnt_q    <= CW'(WIDTH - 1);
			end else if (active_q) begin
				if (cnt_q == '0) begin
					active_q <= 1'b0;
					fin_q    <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (go) begin
			r_q <= '0;
			v_q <= value;
			m_q <= m;
		end else if (active_q) begin
			r_q <= r_next;
			v_q <= {v_q[WIDTH-2:0], 1'b0};
		end
	end

	assign fin = fin_q;
	assign rem = r_q;

endmodule : mexp_modred

`default_nettype wire

// ===== design/mexp_modmul.sv =====
// ----------------------------------------------------------------------------
// mexp_modmul
// Bit-serial interleaved modular multiplier: prod = x * y mod m, x and y
// below m. Scans y from its top bit; each bit takes a doubling step, then an add step.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_modmul #(
	parameter int unsigned WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [WIDTH-1:0] x,
	input  wire logic [WIDTH-1:0] y,
	input  wire logic [WIDTH-1:0] m,
	output logic                  fin,
	output logic [WIDTH-1:0]      prod
);

	localparam int unsigned CW = $clog2(WIDTH);

	logic             active_q;
	logic             add_ph_q;
	logic             fin_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] x_q;
	logic [WIDTH-1:0] y_q;
	logic [WIDTH-1:0] m_q;

	logic [WIDTH-1:0] addend;
	logic [WIDTH:0]   sum;
	logic [WIDTH:0]   diff;
	logic [WIDTH-1:0] acc_next;

	// shared modular adder: doubling in one phase, adding x in the other
	always_comb begin
		addend   = add_ph_q ? x_q : acc_q;
		sum      = {1'b0, acc_q} + {1'b0, addend};
		diff     = sum - {1'b0, m_q};
		acc_next = diff[WIDTH] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			add_ph_q <= 1'b0;
			fin_q    <= 1'b0;
			cnt_q    <= '0;
		end else begin
			fin_q <= 1'b0;
			if (go) begin
				active_q <= 1'b1;
				add_ph_q <= 1'b0;
				cnt_q    <= CW'(WIDTH - 1);
			end else if (active_q) begin
				add_ph_q <= ~add_ph_q;
				if (add_ph_q) begin
					if (cnt_q == '0) begin
						active_q <= 1'b0;
						fin_q    <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
		end else if (active_q) begin
			if (!add_ph_q) begin
				acc_q <= acc_next;
			end else begin
				if (y_q[WIDTH-1]) begin
					acc_q <= acc_next;
				end
				y_q <= {y_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign fin  = fin_q;
	assign prod = acc_q;

endmodule : mexp_modmul

`default_nettype wire

// ===== design/modular_exponentiation_core.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Right-to-left square-and-multiply: base ** exponent mod modulus.
// ----------------------------------------------------------------------------
// Channel   Ports                                            Handshake
// command   base_value, exponent_value, modulus_value        start & !busy
// result    power_result                                     done (1 cycle)
//
// The base is first reduced by a bit-serial divider. For each exponent bit,
// the square and the conditional multiply then run side by side on two
// bit-serial modular multipliers. Scanning stops after the highest set
// exponent bit. Exponent zero or modulus zero skip the arithmetic and go
// straight to the finish state. Reset clears the sequencer; busy stays
// high until done has been shown.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_core
	import mexp_pkg::*;
#(
	parameter int unsigned WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [FIELD_W-1:0] base_value,
	input  wire logic [FIELD_W-1:0] exponent_value,
	input  wire logic [FIELD_W-1:0] modulus_value,
	output logic                    done,
	output logic [FIELD_W-1:0]      power_result
);

	mexp_state_t state_q;
	mexp_state_t state_d;

	logic [WIDTH-1:0] base_w;
	logic [WIDTH-1:0] expo_w;
	logic [WIDTH-1:0] mod_w;

	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] base_q;
	logic [WIDTH-1:0] exp_q;
	logic [WIDTH-1:0] mod_q;

	logic             red_go;
	logic             red_fin;
	logic [WIDTH-1:0] red_rem;
	logic             mul_go;
	logic             sq_fin;
	logic [WIDTH-1:0] sq_prod;
	logic             am_fin;
	logic [WIDTH-1:0] am_prod;
	logic             accept;
	logic             trivial;

	// fit the port words to the operand width
	generate
		if (WIDTH > FIELD_W) begin : g_wide
			assign base_w       = {{(WIDTH-FIELD_W){1'b0}}, base_value};
			assign expo_w       = {{(WIDTH-FIELD_W){1'b0}}, exponent_value};
			assign mod_w        = {{(WIDTH-FIELD_W){1'b0}}, modulus_value};
			assign power_result = acc_q[FIELD_W-1:0];
		end else if (WIDTH == FIELD_W) begin : g_same
			assign base_w       = base_value;
			assign expo_w       = exponent_value;
			assign mod_w        = modulus_value;
			assign power_result = acc_q;
		end else begin : g_narrow
			assign base_w       = base_value[WIDTH-1:0];
			assign expo_w       = exponent_value[WIDTH-1:0];
			assign mod_w        = modulus_value[WIDTH-1:0];
			assign power_result = {{(FIELD_W-WIDTH){1'b0}}, acc_q};
		end
	endgenerate

	assign accept  = start && (state_q == ST_IDLE);
	// zero exponent or zero modulus needs no arithmetic
	assign trivial = (expo_w == '0) || (mod_w == '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = trivial ? ST_FINISH : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (red_fin) begin
					state_d = ST_LAUNCH;
				end
			end
			ST_LAUNCH: begin
				state_d = (exp_q == '0) ? ST_FINISH : ST_MUL;
			end
			ST_MUL: begin
				if (sq_fin) begin
					state_d = ST_LAUNCH;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy   = 1'b1;
		done   = 1'b0;
		red_go = 1'b0;
		mul_go = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				red_go = start && !trivial;
			end
			ST_REDUCE: begin
			end
			ST_LAUNCH: begin
				mul_go = (exp_q != '0);
			end
			ST_MUL: begin
			end
			ST_FINISH: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// accumulator, running base and exponent shift register
	always_ff @(posedge clk) begin
		if (accept) begin
			exp_q <= expo_w;
			mod_q <= mod_w;
			if (expo_w == '0) begin
				acc_q <= WIDTH'(1);
			end else if (mod_w == '0) begin
				acc_q <= '0;
			end else if (mod_w == WIDTH'(1)) begin
				acc_q <= '0;
			end else begin
				acc_q <= WIDTH'(1);
			end
		end else if ((state_q == ST_REDUCE) && red_fin) begin
			base_q <= red_rem;
		end else if ((state_q == ST_MUL) && sq_fin) begin
			base_q <= sq_prod;
			if (exp_q[0] && am_fin) begin
				acc_q <= am_prod;
			end
			exp_q <= {1'b0, exp_q[WIDTH-1:1]};
		end
	end

	// base mod modulus
	mexp_modred #(
		.WIDTH(WIDTH)
	) u_red (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (red_go),
		.value (base_w),
		.m     (mod_w),
		.fin   (red_fin),
		.rem   (red_rem)
	);

	// base squared
	mexp_modmul #(
		.WIDTH(WIDTH)
	) u_sq (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (mul_go),
		.x     (base_q),
		.y     (base_q),
		.m     (mod_q),
		.fin   (sq_fin),
		.prod  (sq_prod)
	);

	// accumulator times base
	mexp_modmul #(
		.WIDTH(WIDTH)
	) u_am (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (mul_go),
		.x     (base_q),
		.y     (acc_q),
		.m     (mod_q),
		.fin   (am_fin),
		.prod  (am_prod)
	);

endmodule : modular_exponentiation_core

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for modular_exponentiation_core. A directed table covers
// the zero exponent, zero and unit moduli, all-ones operands and a few values
// small enough to check by hand. Random words with mixed exponent lengths
// follow. Every done word is compared in order against the expected power:
// a hand-computed value from the table or a 64-bit square-and-multiply computation.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import mexp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_DIRECTED   = 24;
	localparam int N_RANDOM     = 256;
	localparam int CYCLE_LIMIT  = 4_000_000;
	localparam int DRAIN_CYCLES = 20;

	typedef logic [FIELD_W-1:0] word_t;

	// one directed row: operands plus an optional hand-computed power
	typedef struct packed {
		word_t base;
		word_t expo;
		word_t modulus;
		logic  has_known;
		word_t known;
	} stim_row_t;

	// one outstanding power, with its operands for the error line
	typedef struct packed {
		word_t base;
		word_t expo;
		word_t modulus;
		word_t power;
	} pending_power_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	word_t base_value;
	word_t exponent_value;
	word_t modulus_value;
	logic  done;
	word_t power_result;

	pending_power_t pending_powers[$];
	stim_row_t      directed_rows[N_DIRECTED];

	int errors;
	int words_sent;
	int powers_checked;
	int zero_expo_words;
	int full_expo_words;
	int burst_left;
	int cycles;

	modular_exponentiation_core #(
		.WIDTH(FIELD_W)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.base_value    (base_value),
		.exponent_value(exponent_value),
		.modulus_value (modulus_value),
		.done          (done),
		.power_result  (power_result)
	);

	// 2 ns clock
	always #1 clk = ~clk;

	// base ** expo mod modulus by right-to-left square-and-multiply
	function automatic word_t expected_power(input word_t b, input word_t e, input word_t m);
		longint unsigned acc;
		longint unsigned sq;
		longint unsigned mm;
		if (e == '0)
			return word_t'(1);
		if (m == '0)
			return '0;
		mm  = m;
		sq  = b % mm;
		acc = 1 % mm;
		for (int i = 0; i < FIELD_W; i++) begin
			if (e[i])
				acc = (acc * sq) % mm;
			sq = (sq * sq) % mm;
		end
		return word_t'(acc);
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	// present one word at a falling edge, hold it until accepted
	task automatic send_word(input word_t b, input word_t e, input word_t m, input word_t power);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else if ($urandom_range(0, 7) == 0) begin
			gap = 0;
			burst_left = 12;
		end else begin
			gap = $urandom_range(0, 19);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start          <= 1'b1;
		base_value     <= b;
		exponent_value <= e;
		modulus_value  <= m;
		do
			@(posedge clk);
		while (busy);
		pending_powers.push_back('{base: b, expo: e, modulus: m, power: power});
		words_sent++;
		if (e == '0)
			zero_expo_words++;
		if (e[FIELD_W-1])
			full_expo_words++;
		@(negedge clk);
	endtask

	// result checker: one done word against the oldest pending power
	always @(posedge clk) begin
		pending_power_t want;
		if (arst_n && done) begin
			if (pending_powers.size() == 0) begin
				report_mismatch($sformatf("done with nothing pending, power_result=%h",
					power_result));
			end else begin
				want = pending_powers.pop_front();
				powers_checked++;
				if (power_result !== want.power)
					report_mismatch($sformatf("%h ** %h mod %h: power_result=%h, want %h",
						want.base, want.expo, want.modulus, power_result, want.power));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d powers still pending",
				cycles, pending_powers.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		word_t b;
		word_t e;
		word_t m;
		word_t power;
		int    kind;

		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		base_value     = '0;
		exponent_value = '0;
		modulus_value  = '1;
		errors          = 0;
		words_sent      = 0;
		powers_checked  = 0;
		zero_expo_words = 0;
		full_expo_words = 0;
		burst_left      = 0;
		cycles          = 0;

		// directed table: base, exponent, modulus, known?, power
		directed_rows[0]  = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0005, 1'b1, 32'h1};
		directed_rows[1]  = '{32'h0000_0007, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h1};
		directed_rows[2]  = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h1};
		directed_rows[3]  = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h1};
		directed_rows[4]  = '{32'h0000_0005, 32'h0000_0003, 32'h0000_0000, 1'b1, 32'h0};
		directed_rows[5]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0};
		directed_rows[6]  = '{32'h0000_007B, 32'h0000_002D, 32'h0000_0001, 1'b1, 32'h0};
		directed_rows[7]  = '{32'h0000_0000, 32'h0000_0005, 32'h0000_000D, 1'b1, 32'h0};
		directed_rows[8]  = '{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h1};
		directed_rows[9]  = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0};
		directed_rows[10] = '{32'h0000_000A, 32'h0000_0001, 32'h0000_0007, 1'b1, 32'h3};
		directed_rows[11] = '{32'h0000_0064, 32'h0000_0003, 32'h0000_0007, 1'b1, 32'h1};
		directed_rows[12] = '{32'h0000_0002, 32'h0000_000A, 32'h0000_03E8, 1'b1, 32'd24};
		directed_rows[13] = '{32'h0000_0003, 32'h0000_0004, 32'h0000_0064, 1'b1, 32'd81};
		directed_rows[14] = '{32'h0000_0002, 32'h0000_001F, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000};
		directed_rows[15] = '{32'h0000_0002, 32'h0000_0020, 32'hFFFF_FFFF, 1'b1, 32'h1};
		directed_rows[16] = '{32'hFFFF_FFFE, 32'h0000_0002, 32'hFFFF_FFFF, 1'b1, 32'h1};
		directed_rows[17] = '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE};
		directed_rows[18] = '{32'h0000_0003, 32'hFFFF_FFFF, 32'h0000_0002, 1'b1, 32'h1};
		directed_rows[19] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 1'b1, 32'h1};
		directed_rows[20] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0, 32'h0};
		directed_rows[21] = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFF1, 1'b0, 32'h0};
		directed_rows[22] = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 1'b0, 32'h0};
		directed_rows[23] = '{32'hDEAD_BEEF, 32'h1234_5678, 32'hFFFF_FFFE, 1'b0, 32'h0};

		// hold reset, then release it on a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part
		foreach (directed_rows[i]) begin
			if (directed_rows[i].has_known)
				power = directed_rows[i].known;
			else
				power = expected_power(directed_rows[i].base, directed_rows[i].expo,
					directed_rows[i].modulus);
			send_word(directed_rows[i].base, directed_rows[i].expo, directed_rows[i].modulus,
				power);
		end

		// random part: mostly mixed exponent lengths so full-width scans stay rare
		for (int n = 0; n < N_RANDOM; n++) begin
			kind = $urandom_range(0, 9);
			b = $urandom;
			e = $urandom >> $urandom_range(0, 31);
			m = $urandom >> $urandom_range(0, 31);
			case (kind)
				0: e = $urandom | 32'h8000_0000;
				1: m = $urandom_range(1, 16);
				2: begin
					e = $urandom_range(0, 2);
					b = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) : $urandom;
				end
				3: b = m - $urandom_range(0, 2);
				default: ;
			endcase
			if (m == '0)
				m = word_t'(1);
			send_word(b, e, m, expected_power(b, e, m));
		end
		start <= 1'b0;

		// drain, then watch for stray done words
		while (pending_powers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d words (%0d with zero exponent, %0d with exponent MSB set),",
			words_sent, zero_expo_words, full_expo_words);
		$display("checked %0d powers in %0d cycles, %0d mismatches", powers_checked, cycles,
			errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule : testbench

`default_nettype wire

// ===== modular_exponentiation_core.f =====
design/mexp_pkg.sv
design/mexp_modred.sv
design/mexp_modmul.sv
design/modular_exponentiation_core.sv
sim/testbench.sv
